// ===== rtl/spi_eeprom_access_sequencer_defines.svh =====
// Assertion helpers for the block that checks itself.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef SPI_EEPROM_ACCESS_SEQUENCER_DEFINES_SVH
`define SPI_EEPROM_ACCESS_SEQUENCER_DEFINES_SVH

// A condition that must hold at every clock edge out of reset.
`define SEAS_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// A consequence that must hold in the same cycle as its antecedent.
`define SEAS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== rtl/seas_pkg.sv =====
package seas_pkg;

	// Command codes of a request
	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_DATA  = 2'd2;
	localparam logic [1:0] CMD_RECV  = 2'd3;

	// Bus action codes of a result
	localparam logic [2:0] ACT_CS_LOW  = 3'd0;
	localparam logic [2:0] ACT_CS_HIGH = 3'd1;
	localparam logic [2:0] ACT_SEND    = 3'd2;
	localparam logic [2:0] ACT_RECV    = 3'd3;
	localparam logic [2:0] ACT_DATA    = 3'd4;
	localparam logic [2:0] ACT_DONE    = 3'd5;
	localparam logic [2:0] ACT_REJECT  = 3'd6;

	// EEPROM opcodes and status bits
	localparam logic [7:0] OP_READ  = 8'h03;
	localparam logic [7:0] OP_WRITE = 8'h02;
	localparam logic [7:0] OP_WREN  = 8'h06;
	localparam logic [7:0] OP_RDSR  = 8'h05;
	localparam logic [7:0] OP_A8    = 8'h08;
	localparam int         BUSY_BIT = 0;

	// Configuration register indexes
	localparam logic CFG_ADDRESS_MODE = 1'b0;
	localparam logic CFG_PAGE_SIZE    = 1'b1;

	localparam logic [1:0] ADDRESS_MODE_RESET = 2'd1;
	localparam logic [2:0] PAGE_SIZE_RESET    = 3'd4;
	localparam logic [2:0] PAGE_SIZE_MIN      = 3'd4;

	// Fixed order of the steps the back end walks through for one request
	localparam int STEP_FIRST     = 0;
	localparam int STEP_WREN_CSH0 = 1;
	localparam int STEP_WREN_CSL  = 2;
	localparam int STEP_WREN_OP   = 3;
	localparam int STEP_WREN_CSH1 = 4;
	localparam int STEP_HDR_CSL   = 5;
	localparam int STEP_HDR_OP    = 6;
	localparam int STEP_HDR_HI    = 7;
	localparam int STEP_HDR_LO    = 8;
	localparam int STEP_POLL_CSH  = 9;
	localparam int STEP_POLL_CSL  = 10;
	localparam int STEP_POLL_OP   = 11;
	localparam int STEP_RECV      = 12;
	localparam int STEP_DONE      = 13;
	localparam int NUM_STEPS      = 14;
	localparam int STEP_W         = $clog2(NUM_STEPS);

	typedef logic [NUM_STEPS-1:0] steps_t;
	typedef logic [STEP_W-1:0]    step_idx_t;

	localparam steps_t MASK_FIRST = steps_t'(1) << STEP_FIRST;
	localparam steps_t MASK_WREN  = (steps_t'(1) << STEP_WREN_CSH0)
		| (steps_t'(1) << STEP_WREN_CSL) | (steps_t'(1) << STEP_WREN_OP)
		| (steps_t'(1) << STEP_WREN_CSH1);
	localparam steps_t MASK_HDR   = (steps_t'(1) << STEP_HDR_CSL)
		| (steps_t'(1) << STEP_HDR_OP) | (steps_t'(1) << STEP_HDR_LO);
	localparam steps_t MASK_HDR_HI = steps_t'(1) << STEP_HDR_HI;
	localparam steps_t MASK_POLL_FIRST = (steps_t'(1) << STEP_POLL_CSL)
		| (steps_t'(1) << STEP_POLL_OP) | (steps_t'(1) << STEP_RECV);
	localparam steps_t MASK_POLL  = MASK_POLL_FIRST | (steps_t'(1) << STEP_POLL_CSH);
	localparam steps_t MASK_RECV  = steps_t'(1) << STEP_RECV;
	localparam steps_t MASK_END   = (steps_t'(1) << STEP_POLL_CSH)
		| (steps_t'(1) << STEP_DONE);

	// Depth of the job queue between front and back end
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_READ,
		PH_WPOLL,
		PH_WDATA
	} phase_t;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [15:0] start_address;
		logic [15:0] byte_count;
		logic [7:0]  write_byte;
		logic [7:0]  received_byte;
	} cmd_t;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] byte_value;
		logic       last;
	} result_t;

	// One classified request: which steps to emit and the bytes they need
	typedef struct packed {
		steps_t     steps;
		logic [2:0] first_action;
		logic [7:0] first_byte;
		logic [7:0] opcode;
		logic [7:0] addr_hi;
		logic [7:0] addr_lo;
	} job_t;

	typedef struct packed {
		logic              full;
		logic              nonempty;
		logic [QCNT_W-1:0] count;
	} qstat_t;

endpackage

// ===== rtl/spi_eeprom_access_sequencer.sv =====
// SPI EEPROM access sequencer.
// Requests arrive on cmd_valid/cmd_stall/cmd_item: start read, start write,
// write data byte, or a byte clocked in from the SPI bus. Each request is
// turned into a run of bus actions on act_valid/act_stall/act_item, one
// action per cycle while act_stall is low, with last set on the final
// action of the request. A request yields between one and twelve actions.
// The front end classifies a request in the cycle it is taken and queues a
// job; the back end loads the job into its step register and emits the
// job's actions from a single output register. The address mode and page
// size registers are written through cfg_we, cfg_index and cfg_data; the
// user must write them only while no request is in flight, since the
// sequencer itself does not enforce it.
// Reset leaves the sequencer idle, with address mode 1 and 16-byte pages.
// When the receiver holds act_stall, the output action is held, the job
// queue (two entries) fills and cmd_stall then rises until it drains.
module spi_eeprom_access_sequencer #(
	parameter int ADDRESS_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [2:0]        cfg_data,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  seas_pkg::cmd_t    cmd_item,
	output logic              act_valid,
	input  logic              act_stall,
	output seas_pkg::result_t act_item
);

`include "spi_eeprom_access_sequencer_defines.svh"

	seas_pkg::job_t   push_job, head;
	seas_pkg::qstat_t q_stat;
	logic             push, pop;

	seas_front #(
		.ADDRESS_BITS(ADDRESS_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd_valid (cmd_valid),
		.cmd_item  (cmd_item),
		.q_stat    (q_stat),
		.push      (push),
		.job       (push_job)
	);

	seas_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	seas_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.act_valid (act_valid),
		.act_stall (act_stall),
		.act_item  (act_item)
	);

	assign cmd_stall = q_stat.full;

	`SEAS_ASSERT(a_queue_bound, q_stat.count <= seas_pkg::QCNT_W'(seas_pkg::QUEUE_DEPTH), "job queue count beyond depth")
	`SEAS_ASSERT_IMP(a_reject_last, act_valid && act_item.action == seas_pkg::ACT_REJECT, act_item.last, "rejected action not marked last")
	`SEAS_ASSERT_IMP(a_byte_zero, act_valid && act_item.action != seas_pkg::ACT_SEND && act_item.action != seas_pkg::ACT_DATA, act_item.byte_value == 8'd0, "byte value set on an action without data")
	`SEAS_ASSERT_IMP(a_no_pop_empty, pop, q_stat.nonempty, "job taken from an empty queue")

endmodule

// ===== rtl/seas_front.sv =====
module seas_front #(
	parameter int ADDRESS_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [2:0]       cfg_data,
	input  logic             cmd_valid,
	input  seas_pkg::cmd_t   cmd_item,
	input  seas_pkg::qstat_t q_stat,
	output logic             push,
	output seas_pkg::job_t   job
);

	logic [1:0]              address_mode_q;
	logic [2:0]              page_size_log2_q;
	seas_pkg::phase_t        phase_q, phase_d;
	logic [ADDRESS_BITS-1:0] cur_addr_q, cur_addr_d;
	logic [15:0]             rem_q, rem_d;
	logic                    final_q, final_d;

	logic [ADDRESS_BITS-1:0] in_addr, addr_inc, hdr_addr;
	logic [15:0]             hdr16, inc16, rem_dec;
	logic [2:0]              plog;
	logic [6:0]              pmask;
	logic                    boundary;
	logic [7:0]              op_base;
	seas_pkg::steps_t        hdr_steps;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			address_mode_q   <= seas_pkg::ADDRESS_MODE_RESET;
			page_size_log2_q <= seas_pkg::PAGE_SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				seas_pkg::CFG_ADDRESS_MODE: address_mode_q <= cfg_data[1:0];
				seas_pkg::CFG_PAGE_SIZE:    page_size_log2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= seas_pkg::PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_addr_q <= '0;
			rem_q      <= '0;
			final_q    <= 1'b0;
		end else begin
			cur_addr_q <= cur_addr_d;
			rem_q      <= rem_d;
			final_q    <= final_d;
		end
	end

	assign in_addr  = cmd_item.start_address[ADDRESS_BITS-1:0];
	assign addr_inc = cur_addr_q + ADDRESS_BITS'(1);
	assign inc16    = 16'(addr_inc);
	assign rem_dec  = rem_q - 16'd1;
	assign plog     = (page_size_log2_q < seas_pkg::PAGE_SIZE_MIN)
		? seas_pkg::PAGE_SIZE_MIN : page_size_log2_q;
	assign pmask    = 7'((8'd1 << plog) - 8'd1);
	assign boundary = (inc16[6:0] & pmask) == 7'd0;

	// A read header uses the new start address; a write header the running one.
	assign hdr_addr = (phase_q == seas_pkg::PH_IDLE) ? in_addr : cur_addr_q;
	assign hdr16    = 16'(hdr_addr);
	assign op_base  = (cmd_item.cmd == seas_pkg::CMD_READ) ? seas_pkg::OP_READ
		: seas_pkg::OP_WRITE;
	assign hdr_steps = seas_pkg::MASK_HDR
		| (address_mode_q[1] ? seas_pkg::MASK_HDR_HI : '0);

	always_comb begin
		phase_d    = phase_q;
		cur_addr_d = cur_addr_q;
		rem_d      = rem_q;
		final_d    = final_q;
		push       = cmd_valid && !q_stat.full;

		job.steps        = '0;
		job.first_action = seas_pkg::ACT_REJECT;
		job.first_byte   = 8'd0;
		job.addr_hi      = hdr16[15:8];
		job.addr_lo      = hdr16[7:0];
		// In the one-byte mode with A8 the ninth address bit rides in the opcode.
		if (address_mode_q == 2'd1 && hdr16[15:8] != 8'd0) begin
			job.opcode = op_base | seas_pkg::OP_A8;
		end else begin
			job.opcode = op_base;
		end

		if (cmd_item.cmd == seas_pkg::CMD_READ && phase_q == seas_pkg::PH_IDLE) begin
			cur_addr_d = in_addr;
			rem_d      = cmd_item.byte_count;
			if (cmd_item.byte_count == 16'd0) begin
				job.steps = hdr_steps | seas_pkg::MASK_END;
			end else begin
				job.steps = hdr_steps | seas_pkg::MASK_RECV;
				phase_d   = seas_pkg::PH_READ;
			end
		end else if (cmd_item.cmd == seas_pkg::CMD_WRITE
				&& phase_q == seas_pkg::PH_IDLE) begin
			cur_addr_d = in_addr;
			rem_d      = cmd_item.byte_count;
			final_d    = 1'b0;
			job.steps  = seas_pkg::MASK_POLL_FIRST;
			phase_d    = seas_pkg::PH_WPOLL;
		end else if (cmd_item.cmd == seas_pkg::CMD_RECV
				&& phase_q == seas_pkg::PH_READ) begin
			job.first_action = seas_pkg::ACT_DATA;
			job.first_byte   = cmd_item.received_byte;
			rem_d            = rem_dec;
			cur_addr_d       = addr_inc;
			if (rem_dec == 16'd0) begin
				job.steps = seas_pkg::MASK_FIRST | seas_pkg::MASK_END;
				phase_d   = seas_pkg::PH_IDLE;
			end else begin
				job.steps = seas_pkg::MASK_FIRST | seas_pkg::MASK_RECV;
			end
		end else if (cmd_item.cmd == seas_pkg::CMD_RECV
				&& phase_q == seas_pkg::PH_WPOLL) begin
			if (cmd_item.received_byte[seas_pkg::BUSY_BIT]) begin
				job.steps = seas_pkg::MASK_POLL;
			end else if (final_q) begin
				job.steps = seas_pkg::MASK_END;
				final_d   = 1'b0;
				phase_d   = seas_pkg::PH_IDLE;
			end else if (rem_q == 16'd0) begin
				job.steps = seas_pkg::MASK_WREN | hdr_steps | seas_pkg::MASK_POLL;
				final_d   = 1'b1;
			end else begin
				job.steps = seas_pkg::MASK_WREN | hdr_steps;
				phase_d   = seas_pkg::PH_WDATA;
			end
		end else if (cmd_item.cmd == seas_pkg::CMD_DATA
				&& phase_q == seas_pkg::PH_WDATA) begin
			job.first_action = seas_pkg::ACT_SEND;
			job.first_byte   = cmd_item.write_byte;
			rem_d            = rem_dec;
			cur_addr_d       = addr_inc;
			if (rem_dec == 16'd0) begin
				job.steps = seas_pkg::MASK_FIRST | seas_pkg::MASK_POLL;
				final_d   = 1'b1;
				phase_d   = seas_pkg::PH_WPOLL;
			end else if (boundary) begin
				job.steps = seas_pkg::MASK_FIRST | seas_pkg::MASK_POLL;
				final_d   = 1'b0;
				phase_d   = seas_pkg::PH_WPOLL;
			end else begin
				job.steps = seas_pkg::MASK_FIRST;
			end
		end else begin
			job.steps = seas_pkg::MASK_FIRST;
		end

		// Nothing changes unless the request is actually taken.
		if (!push) begin
			phase_d    = phase_q;
			cur_addr_d = cur_addr_q;
			rem_d      = rem_q;
			final_d    = final_q;
		end
	end

endmodule

// ===== rtl/seas_queue.sv =====
module seas_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  seas_pkg::job_t   push_job,
	input  logic             pop,
	output seas_pkg::job_t   head,
	output seas_pkg::qstat_t q_stat
);

	seas_pkg::job_t                  mem_q [seas_pkg::QUEUE_DEPTH];
	logic [seas_pkg::QPTR_W-1:0]     wr_ptr_q, rd_ptr_q;
	logic [seas_pkg::QCNT_W-1:0]     count_q;

	function automatic logic [seas_pkg::QPTR_W-1:0] next_ptr(
		input logic [seas_pkg::QPTR_W-1:0] ptr
	);
		if (ptr == seas_pkg::QPTR_W'(seas_pkg::QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return ptr + seas_pkg::QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + seas_pkg::QCNT_W'(1);
				2'b01:   count_q <= count_q - seas_pkg::QCNT_W'(1);
				default: ;
			endcase
		end
	end

	assign head            = mem_q[rd_ptr_q];
	assign q_stat.full     = count_q == seas_pkg::QCNT_W'(seas_pkg::QUEUE_DEPTH);
	assign q_stat.nonempty = count_q != '0;
	assign q_stat.count    = count_q;

endmodule

// ===== rtl/seas_back.sv =====
module seas_back (
	input  logic              clk,
	input  logic              arst_n,
	input  seas_pkg::job_t    head,
	input  seas_pkg::qstat_t  q_stat,
	output logic              pop,
	output logic              act_valid,
	input  logic              act_stall,
	output seas_pkg::result_t act_item
);

	seas_pkg::steps_t    steps_q, rest;
	seas_pkg::job_t      job_q;
	seas_pkg::result_t   out_q, res;
	logic                out_valid_q;
	seas_pkg::step_idx_t sel;
	logic                advance, emit;

	// Lowest pending step goes out next.
	always_comb begin
		sel = '0;
		for (int i = seas_pkg::NUM_STEPS - 1; i >= 0; i--) begin
			if (steps_q[i]) begin
				sel = seas_pkg::STEP_W'(i);
			end
		end
	end

	assign rest    = steps_q & (steps_q - seas_pkg::steps_t'(1));
	assign advance = !out_valid_q || !act_stall;
	assign emit    = advance && (steps_q != '0);
	// The next job is loaded as the current one gives its final result.
	assign pop     = q_stat.nonempty && ((steps_q == '0) || (emit && rest == '0));

	always_comb begin
		res.last       = rest == '0;
		res.byte_value = 8'd0;
		case (sel)
			seas_pkg::step_idx_t'(seas_pkg::STEP_FIRST): begin
				res.action     = job_q.first_action;
				res.byte_value = job_q.first_byte;
			end
			seas_pkg::step_idx_t'(seas_pkg::STEP_WREN_CSH0): res.action = seas_pkg::ACT_CS_HIGH;
			seas_pkg::step_idx_t'(seas_pkg::STEP_WREN_CSL):  res.action = seas_pkg::ACT_CS_LOW;
			seas_pkg::step_idx_t'(seas_pkg::STEP_WREN_OP): begin
				res.action     = seas_pkg::ACT_SEND;
				res.byte_value = seas_pkg::OP_WREN;
			end
			seas_pkg::step_idx_t'(seas_pkg::STEP_WREN_CSH1): res.action = seas_pkg::ACT_CS_HIGH;
			seas_pkg::step_idx_t'(seas_pkg::STEP_HDR_CSL):   res.action = seas_pkg::ACT_CS_LOW;
			seas_pkg::step_idx_t'(seas_pkg::STEP_HDR_OP): begin
				res.action     = seas_pkg::ACT_SEND;
				res.byte_value = job_q.opcode;
			end
			seas_pkg::step_idx_t'(seas_pkg::STEP_HDR_HI): begin
				res.action     = seas_pkg::ACT_SEND;
				res.byte_value = job_q.addr_hi;
			end
			seas_pkg::step_idx_t'(seas_pkg::STEP_HDR_LO): begin
				res.action     = seas_pkg::ACT_SEND;
				res.byte_value = job_q.addr_lo;
			end
			seas_pkg::step_idx_t'(seas_pkg::STEP_POLL_CSH): res.action = seas_pkg::ACT_CS_HIGH;
			seas_pkg::step_idx_t'(seas_pkg::STEP_POLL_CSL): res.action = seas_pkg::ACT_CS_LOW;
			seas_pkg::step_idx_t'(seas_pkg::STEP_POLL_OP): begin
				res.action     = seas_pkg::ACT_SEND;
				res.byte_value = seas_pkg::OP_RDSR;
			end
			seas_pkg::step_idx_t'(seas_pkg::STEP_RECV): res.action = seas_pkg::ACT_RECV;
			seas_pkg::step_idx_t'(seas_pkg::STEP_DONE): res.action = seas_pkg::ACT_DONE;
			default: res.action = seas_pkg::ACT_REJECT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (advance) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				steps_q <= head.steps;
			end else if (emit) begin
				steps_q <= rest;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= res;
		end
		if (pop) begin
			job_q <= head;
		end
	end

	assign act_valid = out_valid_q;
	assign act_item  = out_q;

endmodule
